// ----- design/bakery_ticket_arbiter_defines.svh -----
// ----------------------------------------------------------------------------
// Bakery ticket arbiter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BAKERY_TICKET_ARBITER_DEFINES_SVH
`define BAKERY_TICKET_ARBITER_DEFINES_SVH

// Checks a property on every rising edge outside reset.
`define BTA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define BTA_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- design/bta_pkg.sv -----
// ----------------------------------------------------------------------------
// Bakery ticket arbiter package
// Sizes, codes, state encoding and structures shared by the arbiter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bta_pkg;

  localparam int CLIENTS      = 16;
  localparam int TICKET_BITS  = 8;
  localparam int CLIENT_W     = 4;
  localparam int TICKET_OUT_W = 8;
  localparam int IDX_W        = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int CNT_W        = $clog2(CLIENTS + 1);
  localparam int EXT_W        = (CNT_W > CLIENT_W) ? CNT_W : CLIENT_W;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 16;

  localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_WAITING    = 2'd1,
    STATUS_OVERFLOW   = 2'd2,
    STATUS_NOT_HOLDER = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RESCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                   busy;
    logic                   last;
    logic [TICKET_BITS-1:0] top;
    logic [TICKET_BITS-1:0] own;
    logic                   found;
    logic [IDX_W-1:0]       holder;
  } scan_res_t;

endpackage

`default_nettype wire

// ----- design/bta_ticket_file.sv -----
// ----------------------------------------------------------------------------
// Bakery ticket file
// One ticket register per client, cleared by reset, one write and one read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bta_ticket_file (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [bta_pkg::IDX_W-1:0]       waddr_i,
  input  logic [bta_pkg::TICKET_BITS-1:0] wdata_i,
  input  logic [bta_pkg::IDX_W-1:0]       raddr_i,
  output logic [bta_pkg::TICKET_BITS-1:0] rdata_o
);

  logic [bta_pkg::TICKET_BITS-1:0] tickets_q [bta_pkg::CLIENTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < bta_pkg::CLIENTS; k++) begin
        tickets_q[k] <= '0;
      end
    end else if (we_i) begin
      tickets_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = tickets_q[raddr_i];

endmodule

`default_nettype wire

// ----- design/bta_scan_unit.sv -----
// ----------------------------------------------------------------------------
// Bakery ticket scan unit
// Walks the ticket file one entry per cycle, tracking the largest ticket,
// the smallest nonzero ticket with its index, and the requester's own ticket.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bta_scan_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [bta_pkg::EXT_W-1:0]       client_i,
  input  logic [bta_pkg::TICKET_BITS-1:0] rd_data_i,
  output logic [bta_pkg::IDX_W-1:0]       rd_addr_o,
  output bta_pkg::scan_res_t              res_o
);

  logic                            busy_q;
  logic [bta_pkg::IDX_W-1:0]       idx_q;
  logic [bta_pkg::TICKET_BITS-1:0] top_q;
  logic [bta_pkg::TICKET_BITS-1:0] best_q;
  logic [bta_pkg::TICKET_BITS-1:0] own_q;
  logic                            found_q;
  logic [bta_pkg::IDX_W-1:0]       holder_q;

  logic idx_last;
  logic own_hit;
  logic take_top;
  logic take_min;

  always_comb begin
    idx_last = (idx_q == bta_pkg::IDX_W'(bta_pkg::CLIENTS - 1));
    own_hit  = (bta_pkg::EXT_W'(idx_q) == client_i);
    take_top = (rd_data_i > top_q);
    take_min = (rd_data_i != '0) && (!found_q || (rd_data_i < best_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= '0;
      top_q    <= '0;
      best_q   <= '0;
      own_q    <= '0;
      found_q  <= 1'b0;
      holder_q <= '0;
    end else if (start_i) begin
      busy_q   <= 1'b1;
      idx_q    <= '0;
      top_q    <= '0;
      best_q   <= '0;
      own_q    <= '0;
      found_q  <= 1'b0;
      holder_q <= '0;
    end else if (busy_q) begin
      if (take_top) begin
        top_q <= rd_data_i;
      end
      if (take_min) begin
        best_q   <= rd_data_i;
        found_q  <= 1'b1;
        holder_q <= idx_q;
      end
      if (own_hit) begin
        own_q <= rd_data_i;
      end
      if (idx_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign rd_addr_o = idx_q;

  always_comb begin
    res_o.busy   = busy_q;
    res_o.last   = busy_q && idx_last;
    res_o.top    = top_q;
    res_o.own    = own_q;
    res_o.found  = found_q;
    res_o.holder = holder_q;
  end

endmodule

`default_nettype wire

// ----- design/bakery_ticket_arbiter.sv -----
// ----------------------------------------------------------------------------
// Bakery ticket arbiter
// Ticket-based lock arbiter: requests draw tickets, the smallest ticket holds.
// ----------------------------------------------------------------------------
// Usage:
// Each slave-side transaction is one event: tuser carries the operation
// (0 request a ticket, 1 release the lock) and tdata carries the client.
// Every event yields exactly one master-side transaction with the status,
// the ticket drawn, and the lock grant after the event.
// The slave side takes one event at a time. A request or a rejected
// release presents its result after a single scan of the ticket file;
// an accepted release scans the file a second time, since the grant is
// found again after the holder's ticket is cleared.
// The next event can be accepted in the cycle after the result is loaded.
// The scan unit reads one ticket per cycle.
// Reset clears every ticket, so no client waits and no lock is granted.
// The result sits in an output register; while the receiver stalls, the
// next event is still accepted and worked on, and its result waits until
// the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bakery_ticket_arbiter_defines.svh"

module bakery_ticket_arbiter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: [3:0] client, [7:4] zero.
  input  logic [bta_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: [0] op.
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: [1:0] status, [9:2] ticket, [10] grant_valid, [14:11] grant_client,
  // [15] zero.
  output logic [bta_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  bta_pkg::state_e    state_q, state_d;
  bta_pkg::scan_res_t scan_res;

  logic                             op_q;
  logic [bta_pkg::CLIENT_W-1:0]     client_q;
  logic [bta_pkg::EXT_W-1:0]        client_ext;
  bta_pkg::status_e                 status_q, status_d;
  logic [bta_pkg::TICKET_OUT_W-1:0] ticket_q, ticket_d;
  logic                             grant_valid_q, grant_valid_d;
  logic [bta_pkg::CLIENT_W-1:0]     grant_client_q, grant_client_d;
  logic                             rescan_q;
  logic                             m_valid_q;
  logic [bta_pkg::OUT_DATA_W-1:0]   m_data_q;

  logic                            s_accept;
  logic                            out_free;
  logic                            scan_start;
  logic                            wr_en;
  logic [bta_pkg::TICKET_BITS-1:0] wr_data;
  logic [bta_pkg::IDX_W-1:0]       rd_addr;
  logic [bta_pkg::TICKET_BITS-1:0] rd_data;
  logic                            in_range;
  logic                            is_holder;
  logic                            req_ok;
  logic                            rel_ok;
  logic [bta_pkg::TICKET_BITS-1:0] new_ticket;
  logic                            load_out;
  logic                            fin_valid;
  logic [bta_pkg::CLIENT_W-1:0]    fin_client;

  assign s_accept   = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_valid_q || m_axis_tready;
  assign client_ext = bta_pkg::EXT_W'(client_q);

  bta_ticket_file u_ticket_file (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (wr_en),
    .waddr_i (bta_pkg::IDX_W'(client_q)),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  bta_scan_unit u_scan_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .client_i  (client_ext),
    .rd_data_i (rd_data),
    .rd_addr_o (rd_addr),
    .res_o     (scan_res)
  );

  always_comb begin
    in_range   = (client_ext < bta_pkg::EXT_W'(bta_pkg::CLIENTS));
    is_holder  = scan_res.found && (bta_pkg::EXT_W'(scan_res.holder) == client_ext);
    new_ticket = scan_res.top + 1'b1;
    req_ok     = in_range && !op_q && (scan_res.own == '0) &&
                 (scan_res.top != bta_pkg::TICKET_MAX);
    rel_ok     = in_range && op_q && is_holder;

    priority if (!in_range) begin
      status_d = bta_pkg::STATUS_NOT_HOLDER;
    end else if (!op_q && (scan_res.own != '0)) begin
      status_d = bta_pkg::STATUS_WAITING;
    end else if (!op_q && (scan_res.top == bta_pkg::TICKET_MAX)) begin
      status_d = bta_pkg::STATUS_OVERFLOW;
    end else if (op_q && !is_holder) begin
      status_d = bta_pkg::STATUS_NOT_HOLDER;
    end else begin
      status_d = bta_pkg::STATUS_OK;
    end

    ticket_d = req_ok ? bta_pkg::TICKET_OUT_W'(new_ticket) : '0;

    if (req_ok) begin
      grant_valid_d  = 1'b1;
      grant_client_d = scan_res.found ? bta_pkg::CLIENT_W'(scan_res.holder) : client_q;
    end else begin
      grant_valid_d  = scan_res.found;
      grant_client_d = scan_res.found ? bta_pkg::CLIENT_W'(scan_res.holder) : '0;
    end

    fin_valid  = rescan_q ? scan_res.found : grant_valid_q;
    fin_client = rescan_q ? (scan_res.found ? bta_pkg::CLIENT_W'(scan_res.holder) : '0)
                          : grant_client_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bta_pkg::ST_IDLE: begin
        if (s_accept) begin
          state_d = bta_pkg::ST_SCAN;
        end
      end
      bta_pkg::ST_SCAN: begin
        if (scan_res.last) begin
          state_d = bta_pkg::ST_DECIDE;
        end
      end
      bta_pkg::ST_DECIDE: begin
        state_d = rel_ok ? bta_pkg::ST_RESCAN : bta_pkg::ST_FINISH;
      end
      bta_pkg::ST_RESCAN: begin
        if (scan_res.last) begin
          state_d = bta_pkg::ST_FINISH;
        end
      end
      bta_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = bta_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bta_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == bta_pkg::ST_IDLE);
    scan_start    = s_accept || ((state_q == bta_pkg::ST_DECIDE) && rel_ok);
    wr_en         = (state_q == bta_pkg::ST_DECIDE) && (req_ok || rel_ok);
    wr_data       = req_ok ? new_ticket : '0;
    load_out      = (state_q == bta_pkg::ST_FINISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bta_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
      rescan_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (state_q == bta_pkg::ST_DECIDE) begin
        rescan_q <= rel_ok;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      op_q     <= s_axis_tuser;
      client_q <= s_axis_tdata[bta_pkg::CLIENT_W-1:0];
    end
    if (state_q == bta_pkg::ST_DECIDE) begin
      status_q       <= status_d;
      ticket_q       <= ticket_d;
      grant_valid_q  <= grant_valid_d;
      grant_client_q <= grant_client_d;
    end
    if (load_out) begin
      m_data_q <= {1'b0, fin_client, fin_valid, ticket_q, status_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `BTA_ASSERT(a_ready_only_when_scan_idle,
              s_axis_tready |-> !scan_res.busy,
              "event accepted during a scan")
  `BTA_ASSERT_NEXT(a_accept_starts_scan,
                   s_accept,
                   scan_res.busy && (state_q == bta_pkg::ST_SCAN),
                   "accepted event did not start a scan")
  `BTA_ASSERT(a_write_only_on_decide,
              wr_en |-> (state_q == bta_pkg::ST_DECIDE) && !scan_res.busy,
              "ticket written outside the decision step")
  `BTA_ASSERT(a_ticket_only_when_ok,
              m_axis_tvalid && (m_axis_tdata[9:2] != '0) |->
                (m_axis_tdata[1:0] == bta_pkg::STATUS_OK),
              "ticket returned with a failing status")

endmodule

`default_nettype wire
